// ===== sv/sws_pkg.sv =====
package sws_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DGRAM = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_PAYLOAD_MAX   = 3'd0,
    REG_RETRY_LIMIT   = 3'd1,
    REG_TIMEOUT_TICKS = 3'd2,
    REG_CLIENT_IP     = 3'd3,
    REG_CLIENT_PORT   = 3'd4
  } reg_e;

  localparam logic [10:0] PAYLOAD_MAX_RST   = 11'd900;
  localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd10;
  localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd1000;
  localparam logic [10:0] PAYLOAD_CAP       = 11'd1024;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] total_size;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic        ack_ok;
    logic [15:0] ack_seq;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] chunk_seq;
    logic [15:0] chunk_offset;
    logic [10:0] chunk_len;
  } res_t;

  typedef struct packed {
    logic [10:0] payload_max;
    logic [3:0]  retry_limit;
    logic [23:0] timeout_ticks;
    logic [31:0] client_ip;
    logic [15:0] client_port;
  } cfg_t;

endpackage

// ===== sv/stop_and_wait_sender_top.sv =====
// Stop-and-wait sender: every request (start, received datagram, tick) yields
// zero or one result (send chunk, done, failed). A request is captured in an
// input register and evaluated, once the output register is free, against
// the transfer state and the configuration, the result landing in an output
// register; one request per cycle is sustained while the result side keeps
// taking. The block stalls input only when both the input register and the
// output register are full and the output is not being taken. Configuration
// writes are always accepted and must be issued while no request is in
// flight.
module stop_and_wait_sender_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] total_size_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic        ack_ok_i,
  input  logic [15:0] ack_seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] chunk_seq_o,
  output logic [15:0] chunk_offset_o,
  output logic [10:0] chunk_len_o
);

  sws_pkg::cfg_t  cfg;
  sws_pkg::item_t item_in;
  sws_pkg::item_t item_q;
  sws_pkg::res_t  res;
  sws_pkg::res_t  res_q;
  logic           item_valid;
  logic           out_free;
  logic           advance;
  logic           res_valid;

  assign item_in.cmd        = cmd_i;
  assign item_in.total_size = total_size_i;
  assign item_in.src_ip     = src_ip_i;
  assign item_in.src_port   = src_port_i;
  assign item_in.ack_ok     = ack_ok_i;
  assign item_in.ack_seq    = ack_seq_i;

  assign advance = item_valid && out_free;

  sws_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sws_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sws_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign kind_o         = res_q.kind;
  assign chunk_seq_o    = res_q.chunk_seq;
  assign chunk_offset_o = res_q.chunk_offset;
  assign chunk_len_o    = res_q.chunk_len;

`ifndef ASSERT_OFF
  // done and failed results carry no chunk description
  a_end_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != sws_pkg::KIND_SEND) |->
      (chunk_seq_o == 16'd0) && (chunk_offset_o == 16'd0) && (chunk_len_o == 11'd0))
    else $error("end result with nonzero chunk fields");

  a_send_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sws_pkg::KIND_SEND) |->
      (chunk_len_o != 11'd0) && (chunk_len_o <= sws_pkg::PAYLOAD_CAP))
    else $error("send request with chunk length out of range");

  // input only stalls when both registers are full and the output is held
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");

  a_no_kind_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> out_valid_o && (kind_o != 2'd3))
    else $error("evaluated result not presented");
`endif

endmodule

// ===== sv/sws_cfg.sv =====
module sws_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output sws_pkg::cfg_t      cfg_o
);

  sws_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sws_pkg::REG_PAYLOAD_MAX:   cfg_d.payload_max   = cfg_data_i[10:0];
        sws_pkg::REG_RETRY_LIMIT:   cfg_d.retry_limit   = cfg_data_i[3:0];
        sws_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[23:0];
        sws_pkg::REG_CLIENT_IP:     cfg_d.client_ip     = cfg_data_i;
        sws_pkg::REG_CLIENT_PORT:   cfg_d.client_port   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_max   <= sws_pkg::PAYLOAD_MAX_RST;
      cfg_q.retry_limit   <= sws_pkg::RETRY_LIMIT_RST;
      cfg_q.timeout_ticks <= sws_pkg::TIMEOUT_TICKS_RST;
      cfg_q.client_ip     <= 32'd0;
      cfg_q.client_port   <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/sws_in_reg.sv =====
module sws_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sws_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output sws_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  sws_pkg::item_t item_q;
  logic           take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== sv/sws_ctrl.sv =====
module sws_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  sws_pkg::item_t item_i,
  input  sws_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  output sws_pkg::res_t  res_o
);

  logic        busy_q, busy_d;
  logic [15:0] size_q, size_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] seq_q, seq_d;
  logic [3:0]  try_q, try_d;
  logic [23:0] timer_q, timer_d;

  logic [10:0] eff_pay;
  logic [3:0]  eff_retry;
  logic [23:0] eff_tmo;
  logic [10:0] len_cur;
  logic [10:0] len_next;
  logic [15:0] size_adv;
  logic [23:0] timer_inc;
  logic        ack_match;

  always_comb begin
    if (cfg_i.payload_max == 11'd0) begin
      eff_pay = 11'd1;
    end else if (cfg_i.payload_max > sws_pkg::PAYLOAD_CAP) begin
      eff_pay = sws_pkg::PAYLOAD_CAP;
    end else begin
      eff_pay = cfg_i.payload_max;
    end
    eff_retry = (cfg_i.retry_limit == 4'd0) ? 4'd1 : cfg_i.retry_limit;
    eff_tmo   = (cfg_i.timeout_ticks == 24'd0) ? 24'd1 : cfg_i.timeout_ticks;
  end

  // chunk length for the current position and for the one after an ack
  assign len_cur   = (size_q < {5'd0, eff_pay}) ? size_q[10:0] : eff_pay;
  assign size_adv  = size_q - {5'd0, len_cur};
  assign len_next  = (size_adv < {5'd0, eff_pay}) ? size_adv[10:0] : eff_pay;
  assign timer_inc = timer_q + 24'd1;
  assign ack_match = (item_i.src_ip == cfg_i.client_ip)
                  && (item_i.src_port == cfg_i.client_port)
                  && item_i.ack_ok && (item_i.ack_seq == seq_q);

  always_comb begin
    logic start_len_sel;
    logic fail_try;
    start_len_sel = (item_i.total_size < {5'd0, eff_pay});
    fail_try      = 1'b0;

    busy_d   = busy_q;
    size_d   = size_q;
    offset_d = offset_q;
    seq_d    = seq_q;
    try_d    = try_q;
    timer_d  = timer_q;

    res_valid_o        = 1'b0;
    res_o.kind         = sws_pkg::KIND_SEND;
    res_o.chunk_seq    = 16'd0;
    res_o.chunk_offset = 16'd0;
    res_o.chunk_len    = 11'd0;

    if (fire_i) begin
      unique case (item_i.cmd)
        sws_pkg::CMD_START: begin
          size_d      = item_i.total_size;
          offset_d    = 16'd0;
          seq_d       = 16'd0;
          timer_d     = 24'd0;
          res_valid_o = 1'b1;
          if (item_i.total_size == 16'd0) begin
            busy_d     = 1'b0;
            try_d      = 4'd0;
            res_o.kind = sws_pkg::KIND_DONE;
          end else begin
            busy_d          = 1'b1;
            try_d           = 4'd1;
            res_o.chunk_len = start_len_sel ? item_i.total_size[10:0] : eff_pay;
          end
        end
        sws_pkg::CMD_DGRAM: begin
          if (busy_q) begin
            if (ack_match) begin
              size_d      = size_adv;
              offset_d    = offset_q + {5'd0, len_cur};
              seq_d       = seq_q + 16'd1;
              timer_d     = 24'd0;
              res_valid_o = 1'b1;
              if (size_adv == 16'd0) begin
                busy_d     = 1'b0;
                res_o.kind = sws_pkg::KIND_DONE;
              end else begin
                try_d              = 4'd1;
                res_o.chunk_seq    = seq_q + 16'd1;
                res_o.chunk_offset = offset_q + {5'd0, len_cur};
                res_o.chunk_len    = len_next;
              end
            end else begin
              fail_try = 1'b1;
            end
          end
        end
        sws_pkg::CMD_TICK: begin
          if (busy_q) begin
            timer_d = timer_inc;
            if (timer_inc >= eff_tmo) begin
              fail_try = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (fail_try) begin
        res_valid_o = 1'b1;
        timer_d     = 24'd0;
        if (try_q >= eff_retry) begin
          busy_d     = 1'b0;
          res_o.kind = sws_pkg::KIND_FAIL;
        end else begin
          try_d              = try_q + 4'd1;
          res_o.chunk_seq    = seq_q;
          res_o.chunk_offset = offset_q;
          res_o.chunk_len    = len_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      size_q   <= 16'd0;
      offset_q <= 16'd0;
      seq_q    <= 16'd0;
      try_q    <= 4'd0;
      timer_q  <= 24'd0;
    end else begin
      busy_q   <= busy_d;
      size_q   <= size_d;
      offset_q <= offset_d;
      seq_q    <= seq_d;
      try_q    <= try_d;
      timer_q  <= timer_d;
    end
  end

endmodule

// ===== sv/sws_out_reg.sv =====
module sws_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          res_valid_i,
  input  sws_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sws_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  sws_pkg::res_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    if (load_i) begin
      valid_d = res_valid_i;
    end else begin
      valid_d = valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
